[rtl/wes_pkg.sv]
// Shared types, constants and the control program of the wheel encoder block.
// No dependencies; every other file in rtl/ imports this package.
package wes_pkg;

  // Default parameter values
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TOTAL_WIDTH_DEF = 48;

  // Field and datapath widths
  localparam int TS_W        = 32;
  localparam int DIST_W      = 16;
  localparam int TICKS_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TOTAL_W = 48;
  localparam int RES_W       = 32;
  localparam int MUL_A_W     = 33;                  // count sum or ticks per second
  localparam int PROD_W      = MUL_A_W + DIST_W;    // 49
  localparam int DIVIDEND_W  = DIST_W + TICKS_W;    // 48
  localparam int DIVISOR_W   = TS_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_DISTANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 1'd1;

  localparam logic [DIST_W-1:0]  EDGE_DISTANCE_RST = 16'd269;
  localparam logic [TICKS_W-1:0] TICKS_PER_SEC_RST = 32'd1000000;

  // Input operation codes
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic            operation;
    logic            wheel;
    logic [TS_W-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [OUT_TOTAL_W-1:0] total_distance_q8;
    logic [RES_W-1:0]       interval_distance_q8;
    logic [RES_W-1:0]       speed_left_q8;
    logic [RES_W-1:0]       speed_right_q8;
  } out_t;

  // Sequencer
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_MUL_INT  = 4'd2;
  localparam step_t ST_ACCUM    = 4'd3;
  localparam step_t ST_DIV_L    = 4'd4;
  localparam step_t ST_WAIT_L   = 4'd5;
  localparam step_t ST_DIV_R    = 4'd6;
  localparam step_t ST_WAIT_R   = 4'd7;
  localparam step_t ST_LOAD_R   = 4'd8;
  localparam step_t ST_WAIT_OUT = 4'd9;
  localparam step_t ST_EMIT     = 4'd10;
  localparam step_t ST_EDGE     = 4'd11;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_INPUT = 3'd2,
    C_IS_EDGE  = 3'd3,
    C_DIV_BUSY = 3'd4,
    C_OUT_FULL = 3'd5
  } cond_t;

  // One control word per step
  typedef struct packed {
    logic  take_in;       // ready for an input transfer, latch the item
    logic  edge_upd;      // period, last time and count update
    logic  mul_interval;  // product <= count sum * edge distance
    logic  mul_speed;     // product <= ticks per second * edge distance
    logic  acc_total;     // latch interval, accumulate total, clear counts
    logic  div_start;     // start the divider on the product
    logic  div_wheel;     // which wheel's period is the divisor
    logic  load_left;     // latch left speed from divider
    logic  load_right;    // latch right speed from divider
    logic  emit;          // load the output register
    cond_t cond;
    step_t target;
  } uword_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic is_report;
    logic div_busy;
    logic out_full;
  } stat_t;

  // Control program
  function automatic uword_t ucode(step_t step);
    uword_t uw;
    uw = '0;
    uw.cond = C_NEXT;
    uw.target = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        uw.take_in = 1'b1;
        uw.cond    = C_NO_INPUT;
        uw.target  = ST_IDLE;
      end
      ST_DISPATCH: begin
        uw.cond   = C_IS_EDGE;
        uw.target = ST_EDGE;
      end
      ST_MUL_INT: uw.mul_interval = 1'b1;
      ST_ACCUM: begin
        uw.acc_total = 1'b1;
        uw.mul_speed = 1'b1;
      end
      ST_DIV_L: begin
        uw.div_start = 1'b1;
        uw.div_wheel = 1'b0;
      end
      ST_WAIT_L: begin
        uw.cond   = C_DIV_BUSY;
        uw.target = ST_WAIT_L;
      end
      ST_DIV_R: begin
        uw.load_left = 1'b1;
        uw.div_start = 1'b1;
        uw.div_wheel = 1'b1;
      end
      ST_WAIT_R: begin
        uw.cond   = C_DIV_BUSY;
        uw.target = ST_WAIT_R;
      end
      ST_LOAD_R: uw.load_right = 1'b1;
      ST_WAIT_OUT: begin
        uw.cond   = C_OUT_FULL;
        uw.target = ST_WAIT_OUT;
      end
      ST_EMIT: begin
        uw.emit   = 1'b1;
        uw.cond   = C_ALWAYS;
        uw.target = ST_IDLE;
      end
      ST_EDGE: begin
        uw.edge_upd = 1'b1;
        uw.cond     = C_ALWAYS;
        uw.target   = ST_IDLE;
      end
      default: begin
        uw.cond   = C_ALWAYS;
        uw.target = ST_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

[rtl/wheel_encoder_speed_distance_core.sv]
// Top level of the two-wheel encoder speed and odometer block.
// Depends on wes_pkg, wes_seq, wes_datapath (which holds wes_div).
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): an edge item names a wheel and
//    its timestamp; a report item asks for one result. Edges give no result.
//  - Output channel (out_valid/out_ready/out_data): one transfer per report,
//    with total distance, interval distance and both wheel speeds.
//  - Config port: cfg_write with cfg_index 0 (edge distance, Q8.8) or
//    1 (ticks per second); write only while the block is idle.
// Sequence:
//  - An edge runs the dispatch and edge-update steps, then in_ready returns.
//  - A report runs the multiply and accumulate steps, then two speed divisions
//    through one bit-serial divider, which dominate; out_valid and in_ready
//    both return together after its emit step.
// Reset: rst (synchronous) clears periods, counts, the total and out_valid,
//  and restores the config defaults. in_ready stays low during reset.
// Stall: a finished result waits in the output register; the block keeps
//  taking items, and a later report holds before its emit step until the
//  output register has been taken.
module wheel_encoder_speed_distance_core #(
  parameter int COUNT_WIDTH = wes_pkg::COUNT_WIDTH_DEF,
  parameter int TOTAL_WIDTH = wes_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wes_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wes_pkg::out_t                  out_data,
  input  logic                           cfg_write,
  input  logic [wes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wes_pkg::*;

  uword_t uw;
  stat_t  stat;

  wes_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .uw       (uw)
  );

  wes_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uw        (uw),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat)
  );

  assign in_ready = uw.take_in && !rst;

  // Checks on sequencer/datapath interplay
  a_emit_into_empty: assert property (@(posedge clk) disable iff (rst)
    uw.emit |-> !out_valid)
    else $error("result emitted over an untaken result");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (rst)
    uw.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_idle_divider: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.div_busy)
    else $error("input taken while a division runs");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken before the first was worked");

endmodule

[rtl/wes_seq.sv]
// Step counter and control ROM: issues one control word per cycle.
// Depends on wes_pkg (control word, conditions, program).
module wes_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  wes_pkg::stat_t stat,
  output wes_pkg::uword_t uw
);
  import wes_pkg::*;

  step_t step;
  logic  jump;

  assign uw = ucode(step);

  // Branch condition select
  always_comb begin
    unique case (uw.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !in_valid;
      C_IS_EDGE:  jump = !stat.is_report;
      C_DIV_BUSY: jump = stat.div_busy;
      C_OUT_FULL: jump = stat.out_full;
      default:    jump = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else if (jump) begin
      step <= uw.target;
    end else begin
      step <= step + 1'b1;
    end
  end

endmodule

[rtl/wes_div.sv]
// Restoring divider, one quotient bit per cycle, flags a zero divisor.
// Depends on wes_pkg (widths).
module wes_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wes_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [wes_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           busy,
  output logic                           div_zero,
  output logic [wes_pkg::DIVIDEND_W-1:0] quotient
);
  import wes_pkg::*;

  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  borrow;

  // Shift in the next dividend bit and try a subtract
  assign trial  = {rem, quotient[DIVIDEND_W-1]};
  assign diff   = trial - {1'b0, dvsr};
  assign borrow = trial < {1'b0, dvsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
      div_zero <= (divisor == '0);
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], !borrow};
      rem      <= borrow ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
    end
  end

endmodule

[rtl/wes_datapath.sv]
// Datapath: config registers, per-wheel edge state, multiplier, accumulator,
// speed registers and output register. Depends on wes_pkg and wes_div.
module wes_datapath #(
  parameter int COUNT_WIDTH = wes_pkg::COUNT_WIDTH_DEF,
  parameter int TOTAL_WIDTH = wes_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wes_pkg::uword_t                uw,
  input  logic                           in_valid,
  input  wes_pkg::in_t                   in_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output wes_pkg::out_t                  out_data,
  input  logic                           cfg_write,
  input  logic [wes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0] cfg_data,
  output wes_pkg::stat_t                 stat
);
  import wes_pkg::*;

  logic [DIST_W-1:0]      edge_distance;
  logic [TICKS_W-1:0]     ticks_per_second;
  in_t                    item;
  logic [TS_W-1:0]        last_edge_time [2];
  logic [TS_W-1:0]        edge_period [2];
  logic [COUNT_WIDTH-1:0] edge_count [2];
  logic [TOTAL_WIDTH-1:0] total;
  logic [TOTAL_WIDTH:0]   total_sum;
  logic [RES_W-1:0]       interval;
  logic [RES_W-1:0]       interval_sat;
  logic [COUNT_WIDTH:0]   count_sum;
  logic [MUL_A_W-1:0]     mul_a;
  logic [PROD_W-1:0]      prod;
  logic [RES_W-1:0]       speed_left;
  logic [RES_W-1:0]       speed_right;
  logic [RES_W-1:0]       speed_q;
  logic                   div_busy;
  logic                   div_zero;
  logic [DIVIDEND_W-1:0]  quotient;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_distance    <= EDGE_DISTANCE_RST;
      ticks_per_second <= TICKS_PER_SEC_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_EDGE_DISTANCE) begin
        edge_distance <= cfg_data[DIST_W-1:0];
      end else if (cfg_index == REG_TICKS_PER_SEC) begin
        ticks_per_second <= cfg_data[TICKS_W-1:0];
      end
    end
  end

  // Latch the item on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else if (uw.take_in && in_valid) begin
      item <= in_data;
    end
  end

  // Per-wheel edge state; counts clear after a report's interval is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        last_edge_time[i] <= '0;
        edge_period[i]    <= '0;
        edge_count[i]     <= '0;
      end
    end else if (uw.edge_upd) begin
      edge_period[item.wheel]    <= item.timestamp - last_edge_time[item.wheel];
      last_edge_time[item.wheel] <= item.timestamp;
      if (edge_count[item.wheel] != '1) begin
        edge_count[item.wheel] <= edge_count[item.wheel] + 1'b1;
      end
    end else if (uw.acc_total) begin
      edge_count[0] <= '0;
      edge_count[1] <= '0;
    end
  end

  // Shared multiplier, registered
  assign count_sum = (COUNT_WIDTH+1)'(edge_count[0]) + (COUNT_WIDTH+1)'(edge_count[1]);
  assign mul_a     = uw.mul_speed ? MUL_A_W'(ticks_per_second) : MUL_A_W'(count_sum);

  always_ff @(posedge clk) begin
    if (uw.mul_interval || uw.mul_speed) begin
      prod <= mul_a * edge_distance;
    end
  end

  // Interval is half the product, saturated; total saturates at its width
  assign interval_sat = (|prod[PROD_W-1:RES_W+1]) ? '1 : prod[RES_W:1];
  assign total_sum    = {1'b0, total} + (TOTAL_WIDTH+1)'(interval_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (uw.acc_total) begin
      total <= total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (uw.acc_total) interval <= interval_sat;
  end

  // Speed division
  wes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uw.div_start),
    .dividend (prod[DIVIDEND_W-1:0]),
    .divisor  (edge_period[uw.div_wheel]),
    .busy     (div_busy),
    .div_zero (div_zero),
    .quotient (quotient)
  );

  assign speed_q = div_zero ? '0
                 : ((|quotient[DIVIDEND_W-1:RES_W]) ? '1 : quotient[RES_W-1:0]);

  always_ff @(posedge clk) begin
    if (uw.load_left)  speed_left  <= speed_q;
    if (uw.load_right) speed_right <= speed_q;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_data.total_distance_q8    <= OUT_TOTAL_W'(total);
      out_data.interval_distance_q8 <= interval;
      out_data.speed_left_q8        <= speed_left;
      out_data.speed_right_q8       <= speed_right;
    end
  end

  assign stat.is_report = (item.operation == OP_REPORT);
  assign stat.div_busy  = div_busy;
  assign stat.out_full  = out_valid;

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the two-wheel encoder speed and odometer core.
// Needs wes_pkg and wheel_encoder_speed_distance_core; the expected reports come
// from a behavioral copy of the block kept inside this module, or from the script.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wes_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          N_SCRIPT    = 14;
  localparam int          N_RANDOM    = 285;   // per random phase, five phases
  localparam int          N_SAT_PAIRS = 12;    // short dense edge train per wheel

  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Behavioral state of the block
  logic [DIST_W-1:0]      cfg_edge_dist = EDGE_DISTANCE_RST;
  logic [TICKS_W-1:0]     cfg_ticks = TICKS_PER_SEC_RST;
  logic [TS_W-1:0]        last_ts [2] = '{default: '0};
  logic [TS_W-1:0]        period [2] = '{default: '0};
  logic [15:0]            edge_cnt [2] = '{default: '0};
  logic [OUT_TOTAL_W-1:0] odo_total = '0;

  out_t            expected_reports [$];
  logic [TS_W-1:0] stim_time [2] = '{default: '0};
  bit              gaps_on = 1'b1;
  int unsigned     mismatches = 0;
  int unsigned     cycles = 0;
  int unsigned     stall_left = 0;

  wheel_encoder_speed_distance_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Speed of one wheel: travel per edge times ticks per second over its period
  function automatic logic [RES_W-1:0] wheel_speed(input bit w);
    logic [63:0] q;
    if (period[w] == '0) return '0;
    q = (64'(cfg_edge_dist) * 64'(cfg_ticks)) / 64'(period[w]);
    return (q > 64'hFFFF_FFFF) ? '1 : q[RES_W-1:0];
  endfunction

  // Apply one item to the odometer state; a report tick yields a result
  function automatic void odometer_step(input in_t it, output bit has_res, output out_t res);
    logic [16:0] cnt_sum;
    logic [63:0] prod;
    logic [31:0] interval;
    has_res = 1'b0;
    res = '0;
    if (it.operation == OP_EDGE) begin
      period[it.wheel] = it.timestamp - last_ts[it.wheel];
      last_ts[it.wheel] = it.timestamp;
      if (edge_cnt[it.wheel] != '1) edge_cnt[it.wheel] = edge_cnt[it.wheel] + 1'b1;
    end else begin
      cnt_sum = 17'(edge_cnt[0]) + 17'(edge_cnt[1]);
      prod = (64'(cnt_sum) * 64'(cfg_edge_dist)) >> 1;
      interval = (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
      // saturating accumulate: headroom is the complement of the total
      if (OUT_TOTAL_W'(interval) > ~odo_total) odo_total = '1;
      else odo_total = odo_total + OUT_TOTAL_W'(interval);
      res.total_distance_q8    = odo_total;
      res.interval_distance_q8 = interval;
      res.speed_left_q8        = wheel_speed(1'b0);
      res.speed_right_q8       = wheel_speed(1'b1);
      edge_cnt[0] = '0;
      edge_cnt[1] = '0;
      has_res = 1'b1;
    end
  endfunction

  function automatic script_row_t script_row(input logic op, input logic w,
                                             input logic [31:0] ts, input bit typed,
                                             input out_t res);
    script_row_t r;
    r.item.operation = op;
    r.item.wheel     = w;
    r.item.timestamp = ts;
    r.typed          = typed;
    r.res            = res;
    return r;
  endfunction

  // Mostly plausible edge trains per wheel, some reports, some wild timestamps
  function automatic in_t random_item();
    in_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.wheel = 1'($urandom_range(0, 1));
    if (r < 17) begin
      it.operation = OP_REPORT;
      it.timestamp = $urandom();
    end else begin
      it.operation = OP_EDGE;
      if (r < 70)      it.timestamp = stim_time[it.wheel] + $urandom_range(1, 5000);
      else if (r < 85) it.timestamp = stim_time[it.wheel] + $urandom_range(0, 3);
      else             it.timestamp = $urandom();
      stim_time[it.wheel] = it.timestamp;
    end
    return it;
  endfunction

  // One input transfer, with an optional idle burst ahead of it
  task automatic send(input in_t it, input bit typed, input out_t typed_res);
    int   gap;
    bit   has_res;
    out_t res;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    odometer_step(it, has_res, res);
    if (has_res) expected_reports.push_back(typed ? typed_res : res);
  endtask

  // Let every pending report drain and any edge finish its update
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] dist_word,
                            input logic [CFG_DATA_W-1:0] ticks_word);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_EDGE_DISTANCE;
    cfg_data  <= dist_word;
    @(posedge clk);
    cfg_index <= REG_TICKS_PER_SEC;
    cfg_data  <= ticks_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_edge_dist = dist_word[DIST_W-1:0];
    cfg_ticks     = ticks_word;
  endtask

  task automatic random_phase(input bit with_gaps);
    gaps_on = with_gaps;
    repeat (N_RANDOM) send(random_item(), 1'b0, '0);
  endtask

  // Output side: random stall bursts while gaps are on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp,
                             input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  // Compare each output transfer with the oldest pending report
  always @(posedge clk) begin
    out_t exp;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("report transfer with no report pending");
        mismatches++;
      end else begin
        exp = expected_reports.pop_front();
        check_field("total_distance_q8", 64'(exp.total_distance_q8),
                    64'(out_data.total_distance_q8));
        check_field("interval_distance_q8", 64'(exp.interval_distance_q8),
                    64'(out_data.interval_distance_q8));
        check_field("speed_left_q8", 64'(exp.speed_left_q8),
                    64'(out_data.speed_left_q8));
        check_field("speed_right_q8", 64'(exp.speed_right_q8),
                    64'(out_data.speed_right_q8));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[wheel_encoder_speed_distance_core] ERROR");
      $finish;
    end
  end

  initial begin
    script_row_t script [N_SCRIPT];
    in_t         it;
    script = '{
      // report straight after reset: all zero
      script_row(OP_REPORT, 1'b0, 32'd0,          1'b1, '{48'd0, 32'd0, 32'd0, 32'd0}),
      // first left edge at time zero leaves a zero period
      script_row(OP_EDGE,   1'b0, 32'd0,          1'b0, '0),
      script_row(OP_EDGE,   1'b1, 32'd1000,       1'b0, '0),
      // wheel bit ignored on a report; one edge each at 1.05 cm
      script_row(OP_REPORT, 1'b1, 32'hFFFF_FFFF,  1'b1,
                 '{48'd269, 32'd269, 32'd0, 32'd269000}),
      script_row(OP_EDGE,   1'b0, 32'hFFFF_FFFF,  1'b0, '0),
      // timestamp wraps
      script_row(OP_EDGE,   1'b0, 32'd5,          1'b0, '0),
      script_row(OP_EDGE,   1'b1, 32'hFFFF_FFFF,  1'b0, '0),
      script_row(OP_EDGE,   1'b1, 32'd1000,       1'b0, '0),
      script_row(OP_REPORT, 1'b0, 32'd0,          1'b0, '0),
      // repeated timestamp gives a zero period again
      script_row(OP_EDGE,   1'b0, 32'd5,          1'b0, '0),
      script_row(OP_REPORT, 1'b0, 32'h8000_0000,  1'b0, '0),
      // report with no edges in between
      script_row(OP_REPORT, 1'b1, 32'd1,          1'b0, '0),
      // one-tick period, fastest speed
      script_row(OP_EDGE,   1'b1, 32'd1001,       1'b0, '0),
      script_row(OP_REPORT, 1'b0, 32'd0,          1'b0, '0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    gaps_on = 1'b1;
    foreach (script[i]) send(script[i].item, script[i].typed, script[i].res);

    // extremes: widest distance and tick rate saturate the speeds
    set_config(32'h0000_FFFF, 32'hFFFF_FFFF);
    random_phase(1'b1);
    // upper data bits dropped, distance zero, slowest tick rate
    set_config(32'hA5C3_0000, 32'd1);
    random_phase(1'b0);
    // zero tick rate: both speeds read zero
    set_config({16'h0000, 16'($urandom())}, 32'd0);
    random_phase(1'b1);
    set_config($urandom(), $urandom());
    random_phase(1'b1);

    // dense edge trains on both wheels at the widest distance, then a report
    set_config(32'h0000_FFFF, 32'd1000000);
    gaps_on = 1'b0;
    repeat (N_SAT_PAIRS) begin
      for (int w = 0; w < 2; w++) begin
        it.operation = OP_EDGE;
        it.wheel     = 1'(w);
        it.timestamp = stim_time[w] + $urandom_range(1, 300);
        stim_time[w] = it.timestamp;
        send(it, 1'b0, '0);
      end
    end
    it.operation = OP_REPORT;
    it.wheel     = 1'b0;
    it.timestamp = '0;
    send(it, 1'b0, '0);

    // back to the power-on values, no idling to the end
    set_config(32'(EDGE_DISTANCE_RST), TICKS_PER_SEC_RST);
    random_phase(1'b0);

    drain();
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("[wheel_encoder_speed_distance_core] OK");
    end else begin
      $display("[wheel_encoder_speed_distance_core] ERROR");
    end
    $finish;
  end

endmodule
